>>> rtl/core/tpt_pkg.sv
// tpt_pkg: sizes and the operation, status, error and register codes of the
// two-region page table core. Depends on nothing; used by the core by scoped names.
package tpt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int PAGE_BITS   = 12;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int VA_W    = 32;
  localparam int PAGE_W  = VA_W - PAGE_BITS;
  localparam int START_W = 20;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 20;
  localparam int CMP_W   = (PAGE_W > START_W) ? PAGE_W : START_W;
  localparam int LOC_W   = (IDX_W > COUNT_W + 1) ? IDX_W : COUNT_W + 1;

  localparam logic [1:0] OP_MAP         = 2'd0;
  localparam logic [1:0] OP_LOOKUP      = 2'd1;
  localparam logic [1:0] OP_SWAP_OUT    = 2'd2;
  localparam logic [1:0] OP_READ_OFFSET = 2'd3;

  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_SWAPPED = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_STATE = 2'd2;

  localparam logic [1:0] REG_R1_START = 2'd0;
  localparam logic [1:0] REG_R1_PAGES = 2'd1;
  localparam logic [1:0] REG_R2_START = 2'd2;
  localparam logic [1:0] REG_R2_PAGES = 2'd3;

endpackage

>>> rtl/core/two_region_page_table_core.sv
// two_region_page_table_core: flat page table over two virtual regions, held
// in a synchronous status memory and a synchronous entry memory. Depends on tpt_pkg.

// A request is taken when start is high and busy is low; its result is registered
// into the output ports at the end of the access state, with done high for a
// single cycle, and cannot be held off. The core takes no new request until the
// last one is through:
// the entry index is worked out and the memories read at the accepting edge, and
// the following cycle checks the status and writes the entry back. After reset
// the core runs a clearing pass over the status memory, one entry a cycle, so
// busy stays high until every entry is cleared, before the first
// request; configuration writes are taken during that pass as at any other time.
module two_region_page_table_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [tpt_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  operation,
  input  logic [31:0]                 virtual_address,
  input  logic [31:0]                 physical_address,
  input  logic [2:0]                  permission_bits,
  input  logic [31:0]                 swap_offset,
  output logic                        done,
  output logic [1:0]                  entry_status,
  output logic [31:0]                 frame_address,
  output logic [2:0]                  frame_permissions,
  output logic [31:0]                 stored_offset,
  output logic [1:0]                  error_code
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_ACCESS = 3'b010,
    S_CLEAR  = 3'b100
  } state_t;

  typedef struct packed {
    logic [31:0] frame;
    logic [2:0]  perm;
    logic [31:0] offset;
  } entry_t;

  state_t state, state_next;

  // configuration registers
  logic [tpt_pkg::START_W-1:0] r1_start, r2_start;
  logic [tpt_pkg::COUNT_W-1:0] r1_pages, r2_pages;

  // memories
  logic [1:0]  status_mem [tpt_pkg::TABLE_DEPTH];
  entry_t      entry_mem  [tpt_pkg::TABLE_DEPTH];

  logic [1:0]  st_q;
  entry_t      entry_q;

  // request held for the access cycle
  logic [1:0]                req_op;
  logic [31:0]               req_paddr;
  logic [2:0]                req_perm;
  logic [31:0]               req_soff;
  logic                      req_ok;
  logic [tpt_pkg::IDX_W-1:0] req_idx;

  logic [tpt_pkg::IDX_W-1:0] clear_idx;

  // index calculation
  logic                      accept;
  logic [tpt_pkg::CMP_W-1:0] page_e, s1_e, s2_e, d1, d2;
  logic                      in1, in2;
  logic [tpt_pkg::LOC_W-1:0] loc2;
  logic [tpt_pkg::LOC_W-1:0] loc;
  logic                      loc_ok;
  logic [tpt_pkg::IDX_W-1:0] loc_idx;

  // access cycle results
  logic [1:0]                res_status, res_err;
  logic [31:0]               res_frame, res_off;
  logic [2:0]                res_perm;
  logic                      st_we, fr_we, off_we;
  logic [1:0]                st_wdata;
  logic [tpt_pkg::IDX_W-1:0] st_waddr;
  logic                      entry_we;
  entry_t                    entry_wdata;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign page_e = tpt_pkg::CMP_W'(virtual_address[31:tpt_pkg::PAGE_BITS]);
  assign s1_e   = tpt_pkg::CMP_W'(r1_start);
  assign s2_e   = tpt_pkg::CMP_W'(r2_start);
  assign d1     = page_e - s1_e;
  assign d2     = page_e - s2_e;
  assign in1    = (page_e >= s1_e) && (d1 < tpt_pkg::CMP_W'(r1_pages));
  assign in2    = (page_e >= s2_e) && (d2 < tpt_pkg::CMP_W'(r2_pages));
  // offset fits the count width whenever the page is inside the region
  assign loc2   = tpt_pkg::LOC_W'(r1_pages) + tpt_pkg::LOC_W'(d2[tpt_pkg::COUNT_W-1:0]);

  always_comb begin
    if (in2) begin
      loc = loc2;
    end else begin
      loc = tpt_pkg::LOC_W'(d1[tpt_pkg::COUNT_W-1:0]);
    end
  end

  assign loc_ok  = (in1 || in2) &&
                   ((tpt_pkg::LOC_W + 1)'(loc) < (tpt_pkg::LOC_W + 1)'(tpt_pkg::TABLE_DEPTH));
  assign loc_idx = loc[tpt_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_start <= '0;
      r1_pages <= tpt_pkg::COUNT_W'(1);
      r2_start <= '0;
      r2_pages <= tpt_pkg::COUNT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        tpt_pkg::REG_R1_START: r1_start <= cfg_data[tpt_pkg::START_W-1:0];
        tpt_pkg::REG_R1_PAGES: r1_pages <= cfg_data[tpt_pkg::COUNT_W-1:0];
        tpt_pkg::REG_R2_START: r2_start <= cfg_data[tpt_pkg::START_W-1:0];
        tpt_pkg::REG_R2_PAGES: r2_pages <= cfg_data[tpt_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_ACCESS;
      end
      S_ACCESS: state_next = S_IDLE;
      S_CLEAR: begin
        if (clear_idx == tpt_pkg::IDX_W'(tpt_pkg::TABLE_DEPTH - 1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clear_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clear_idx <= clear_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= operation;
      req_paddr <= physical_address;
      req_perm  <= permission_bits;
      req_soff  <= swap_offset;
      req_ok    <= loc_ok;
      req_idx   <= loc_idx;
    end
  end

  // entry check and write-back
  always_comb begin
    res_status = tpt_pkg::ST_EMPTY;
    res_err    = tpt_pkg::ERR_OK;
    res_frame  = '0;
    res_perm   = '0;
    res_off    = '0;
    st_we      = 1'b0;
    fr_we      = 1'b0;
    off_we     = 1'b0;
    st_wdata   = tpt_pkg::ST_EMPTY;
    if (!req_ok) begin
      res_err = tpt_pkg::ERR_RANGE;
    end else begin
      res_status = st_q;
      case (req_op)
        tpt_pkg::OP_MAP: begin
          if (st_q == tpt_pkg::ST_VALID) begin
            res_err = tpt_pkg::ERR_STATE;
          end else begin
            res_status = tpt_pkg::ST_VALID;
            st_we      = 1'b1;
            st_wdata   = tpt_pkg::ST_VALID;
            fr_we      = 1'b1;
          end
        end
        tpt_pkg::OP_LOOKUP: begin
          if (st_q == tpt_pkg::ST_VALID) begin
            res_frame = entry_q.frame;
            res_perm  = entry_q.perm;
          end
        end
        tpt_pkg::OP_SWAP_OUT: begin
          if (st_q != tpt_pkg::ST_VALID) begin
            res_err = tpt_pkg::ERR_STATE;
          end else begin
            res_status = tpt_pkg::ST_SWAPPED;
            st_we      = 1'b1;
            st_wdata   = tpt_pkg::ST_SWAPPED;
            off_we     = 1'b1;
          end
        end
        default: begin
          if (st_q != tpt_pkg::ST_SWAPPED) begin
            res_err = tpt_pkg::ERR_STATE;
          end else begin
            res_off = entry_q.offset;
          end
        end
      endcase
    end
  end

  // entry word: fields that the request does not touch are written back as read
  assign entry_we = fr_we || off_we;

  always_comb begin
    entry_wdata = entry_q;
    if (fr_we) begin
      entry_wdata.frame = req_paddr;
      entry_wdata.perm  = req_perm;
    end
    if (off_we) entry_wdata.offset = req_soff;
  end

  // status memory port: clearing pass or write-back
  always_comb begin
    if (state == S_CLEAR) begin
      st_waddr = clear_idx;
    end else begin
      st_waddr = req_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      status_mem[st_waddr] <= tpt_pkg::ST_EMPTY;
    end else if (state == S_ACCESS && st_we) begin
      status_mem[st_waddr] <= st_wdata;
    end
    if (accept) st_q <= status_mem[loc_idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_ACCESS && entry_we) begin
      entry_mem[req_idx] <= entry_wdata;
    end
    if (accept) entry_q <= entry_mem[loc_idx];
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_ACCESS);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ACCESS) begin
      entry_status      <= res_status;
      frame_address     <= res_frame;
      frame_permissions <= res_perm;
      stored_offset     <= res_off;
      error_code        <= res_err;
    end
  end

  a_done_after_access: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_ACCESS))
    else $error("result word without an access cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && !done) ##1 (done && !busy))
    else $error("request not answered two cycles after acceptance");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error_code == tpt_pkg::ERR_RANGE) |->
      (entry_status == tpt_pkg::ST_EMPTY && frame_address == '0 &&
       frame_permissions == '0 && stored_offset == '0))
    else $error("out of range word carries data");

  a_perm_only_valid: assert property (@(posedge clk) disable iff (rst)
    (done && frame_permissions != '0) |->
      (entry_status == tpt_pkg::ST_VALID && error_code == tpt_pkg::ERR_OK))
    else $error("permissions returned for an entry that is not valid");

  a_offset_only_swapped: assert property (@(posedge clk) disable iff (rst)
    (done && stored_offset != '0) |->
      (entry_status == tpt_pkg::ST_SWAPPED && error_code == tpt_pkg::ERR_OK))
    else $error("offset returned for an entry that is not swapped");

endmodule
